// ----- rtl/vfm_pkg.sv -----
// Shared constants, control word types and corner tables of the voxel face mesher.
`timescale 1ns / 1ps
package vfm_pkg;

  // Grid geometry
  localparam int MAX_SIZE = 32;
  localparam int COORD_W  = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 6;
  localparam int ROW_AW   = 2 * COORD_W;
  localparam int VS_W     = 16;
  localparam int POS_W    = 21;
  localparam int FACE_W   = 3;
  localparam int VTX_W    = 3;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Register reset values and register indexes
  localparam logic [SIZE_W-1:0] ACTIVE_RESET  = SIZE_W'(32);
  localparam logic [VS_W-1:0]   VOXEL_RESET   = VS_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT    = SIZE_W'(MAX_SIZE);
  localparam logic              REG_ACTIVE_SIZE = 1'b0;
  localparam logic              REG_VOXEL_SIZE  = 1'b1;

  // Input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  // Face direction codes
  localparam logic [FACE_W-1:0] FACE_ZP = 3'd0;
  localparam logic [FACE_W-1:0] FACE_ZM = 3'd1;
  localparam logic [FACE_W-1:0] FACE_XP = 3'd2;
  localparam logic [FACE_W-1:0] FACE_XM = 3'd3;
  localparam logic [FACE_W-1:0] FACE_YP = 3'd4;
  localparam logic [FACE_W-1:0] FACE_YM = 3'd5;
  localparam int               NFACES  = 6;
  localparam logic [VTX_W-1:0] VTX_LAST = 3'd5;

  // Sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_RD_C   = 4'd1;
  localparam logic [STEP_W-1:0] ST_CAP_C  = 4'd2;
  localparam logic [STEP_W-1:0] ST_CAP_ZP = 4'd3;
  localparam logic [STEP_W-1:0] ST_CAP_ZM = 4'd4;
  localparam logic [STEP_W-1:0] ST_CAP_YP = 4'd5;
  localparam logic [STEP_W-1:0] ST_CAP_YM = 4'd6;
  localparam logic [STEP_W-1:0] ST_EMIT   = 4'd7;
  localparam logic [STEP_W-1:0] ST_WRITE  = 4'd8;

  // Row read selects
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_CENTER = 3'd1;
  localparam logic [2:0] RD_ZP     = 3'd2;
  localparam logic [2:0] RD_ZM     = 3'd3;
  localparam logic [2:0] RD_YP     = 3'd4;
  localparam logic [2:0] RD_YM     = 3'd5;

  // Capture selects for the registered read row
  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_C    = 3'd1;
  localparam logic [2:0] CAP_ZP   = 3'd2;
  localparam logic [2:0] CAP_ZM   = 3'd3;
  localparam logic [2:0] CAP_YP   = 3'd4;
  localparam logic [2:0] CAP_YM   = 3'd5;

  // Branch conditions
  localparam logic [2:0] CD_NEXT     = 3'd0;
  localparam logic [2:0] CD_ACCEPT   = 3'd1;
  localparam logic [2:0] CD_IF_WRITE = 3'd2;
  localparam logic [2:0] CD_EMIT     = 3'd3;
  localparam logic [2:0] CD_GOTO     = 3'd4;

  // One control word of the program
  typedef struct packed {
    logic [2:0]        rd_sel;
    logic              wr;
    logic [2:0]        cap;
    logic              emit;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status fed back from the datapath to the sequencer
  typedef struct packed {
    logic accept;
    logic is_write;
    logic emit_done;
  } seq_flags_t;

  // Program store: one control word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{rd_sel: RD_NONE, wr: 1'b0, cap: CAP_NONE, emit: 1'b0,
          cond: CD_GOTO, target: ST_IDLE};
    unique case (step)
      ST_IDLE:   w.cond = CD_ACCEPT;
      ST_RD_C: begin
        w.rd_sel = RD_CENTER;
        w.cond   = CD_NEXT;
      end
      ST_CAP_C: begin
        w.cap    = CAP_C;
        w.rd_sel = RD_ZP;
        w.cond   = CD_IF_WRITE;
        w.target = ST_WRITE;
      end
      ST_CAP_ZP: begin
        w.cap    = CAP_ZP;
        w.rd_sel = RD_ZM;
        w.cond   = CD_NEXT;
      end
      ST_CAP_ZM: begin
        w.cap    = CAP_ZM;
        w.rd_sel = RD_YP;
        w.cond   = CD_NEXT;
      end
      ST_CAP_YP: begin
        w.cap    = CAP_YP;
        w.rd_sel = RD_YM;
        w.cond   = CD_NEXT;
      end
      ST_CAP_YM: begin
        w.cap  = CAP_YM;
        w.cond = CD_NEXT;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = CD_EMIT;
        w.target = ST_IDLE;
      end
      ST_WRITE: begin
        w.wr     = 1'b1;
        w.cond   = CD_GOTO;
        w.target = ST_IDLE;
      end
      default: w.cond = CD_GOTO;
    endcase
    return w;
  endfunction

  // Corner offset {x, y, z} of one vertex of a face; vertices run bl, br, tl, br, tr, tl.
  function automatic logic [2:0] vfm_corner(input logic [FACE_W-1:0] face,
                                            input logic [VTX_W-1:0]  vtx);
    logic [1:0]  k;
    logic [11:0] row;
    case (vtx)
      3'd0:    k = 2'd0;
      3'd1:    k = 2'd1;
      3'd2:    k = 2'd2;
      3'd3:    k = 2'd1;
      3'd4:    k = 2'd3;
      default: k = 2'd2;
    endcase
    // Packed as {tr, tl, br, bl}
    case (face)
      FACE_ZP: row = {3'b111, 3'b011, 3'b101, 3'b001};
      FACE_ZM: row = {3'b010, 3'b110, 3'b000, 3'b100};
      FACE_XP: row = {3'b110, 3'b111, 3'b100, 3'b101};
      FACE_XM: row = {3'b011, 3'b010, 3'b001, 3'b000};
      FACE_YP: row = {3'b110, 3'b010, 3'b111, 3'b011};
      default: row = {3'b101, 3'b001, 3'b100, 3'b000};
    endcase
    return row[k*3 +: 3];
  endfunction

endpackage

// ----- rtl/voxel_face_culling_mesher.sv -----
// Top level of the culled voxel face mesher: ports, registers and datapath.
`timescale 1ns / 1ps
// Usage
// The input channel (in_valid/in_ready) takes one item per beat: opcode 0 writes
// the solid bit of one voxel, opcode 1 asks for the visible faces of one voxel.
// The output channel (out_valid/out_ready) gives one vertex per beat, six per
// visible face in the order +z, -z, +x, -x, +y, -y, with last on the final one.
// The APB port sets active_size (address 0) and voxel_size (address 4); write
// them only while the block is idle.
// A write item passes through the idle (accept), centre read, centre capture
// and write steps. An emit item reads the centre row and four neighbour rows,
// one row at a time through the single read port of the voxel store, then
// gives one vertex per beat; a voxel with no visible face ends the item with
// no vertex at all.
// An output register holds each vertex; while the receiver stalls the
// sequencer waits in its emit step and no vertex is lost.
// After reset the voxel store is swept to empty, row by row through all 1024
// rows; in_ready stays low meanwhile, and configuration writes still work.
module voxel_face_culling_mesher (
  input  logic                          clk,
  input  logic                          rst,
  // Input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [vfm_pkg::COORD_W-1:0]   coord_x,
  input  logic [vfm_pkg::COORD_W-1:0]   coord_y,
  input  logic [vfm_pkg::COORD_W-1:0]   coord_z,
  input  logic                          solid,
  // Vertices
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vfm_pkg::POS_W-1:0]     pos_x,
  output logic [vfm_pkg::POS_W-1:0]     pos_y,
  output logic [vfm_pkg::POS_W-1:0]     pos_z,
  output logic [vfm_pkg::FACE_W-1:0]    face_dir,
  output logic                          last,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vfm_pkg::PADDR_W-1:0]   paddr,
  input  logic [vfm_pkg::DATA_W-1:0]    pwdata,
  output logic [vfm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import vfm_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] active_size;
  logic [VS_W-1:0]   voxel_size;

  // Item registers
  logic                op;
  logic [COORD_W-1:0]  cx;
  logic [COORD_W-1:0]  cy;
  logic [COORD_W-1:0]  cz;
  logic                sol;
  logic [MAX_SIZE-1:0] row;
  logic                csolid;
  logic [NFACES-1:0]   pend;
  logic [VTX_W-1:0]    vcnt;
  logic [POS_W-1:0]    lo_x, lo_y, lo_z;
  logic [POS_W-1:0]    hi_x, hi_y, hi_z;

  // Sequencer and store signals
  logic [STEP_W-1:0]   step;
  ucode_t              uc;
  seq_flags_t          flags;
  logic                clr_busy;
  logic                accept;
  logic                rd_en;
  logic [ROW_AW-1:0]   rd_addr;
  logic [MAX_SIZE-1:0] rd_data;
  logic                wr_en;
  logic [MAX_SIZE-1:0] wr_row;

  // Combinational datapath
  logic [SIZE_W-1:0]   eff;
  logic                x_in, y_in, z_in, center_in;
  logic                xp_ok, yp_ok, zp_ok;
  logic [COORD_W-1:0]  cx_inc, cx_dec, cy_inc, cy_dec, cz_inc, cz_dec;
  logic [NFACES-1:0]   mask;
  logic [FACE_W-1:0]   cur;
  logic                one_left;
  logic                slot_free;
  logic                fire;
  logic                last_v;
  logic [2:0]          corner;
  logic                cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_RESET;
      voxel_size  <= VOXEL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE_SIZE: active_size <= pwdata[SIZE_W-1:0];
        default:         voxel_size  <= pwdata[VS_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_SIZE: prdata = DATA_W'(active_size);
      default:         prdata = DATA_W'(voxel_size);
    endcase
  end

  // Sequencer and voxel store
  assign in_ready = (step == ST_IDLE) && !clr_busy;
  assign accept   = in_valid && in_ready;

  assign flags.accept    = accept;
  assign flags.is_write  = (op == OP_WRITE);
  assign flags.emit_done = uc.emit && ((mask == '0) || (fire && last_v));

  vfm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .step  (step),
    .uc    (uc)
  );

  vfm_grid u_grid (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr ({cz, cy}),
    .wr_data (wr_row),
    .busy    (clr_busy)
  );

  // Bounds against the active size, clamped to the grid edge.
  assign eff       = (active_size > SIZE_LIMIT) ? SIZE_LIMIT : active_size;
  assign x_in      = {1'b0, cx} < eff;
  assign y_in      = {1'b0, cy} < eff;
  assign z_in      = {1'b0, cz} < eff;
  assign center_in = x_in && y_in && z_in;
  assign xp_ok     = ({1'b0, cx} + SIZE_W'(1)) < eff;
  assign yp_ok     = ({1'b0, cy} + SIZE_W'(1)) < eff;
  assign zp_ok     = ({1'b0, cz} + SIZE_W'(1)) < eff;
  assign cx_inc    = cx + COORD_W'(1);
  assign cx_dec    = cx - COORD_W'(1);
  assign cy_inc    = cy + COORD_W'(1);
  assign cy_dec    = cy - COORD_W'(1);
  assign cz_inc    = cz + COORD_W'(1);
  assign cz_dec    = cz - COORD_W'(1);

  // Row address for the read the control word asks for.
  assign rd_en = (uc.rd_sel != RD_NONE);
  always_comb begin
    case (uc.rd_sel)
      RD_ZP:   rd_addr = {cz_inc, cy};
      RD_ZM:   rd_addr = {cz_dec, cy};
      RD_YP:   rd_addr = {cz, cy_inc};
      RD_YM:   rd_addr = {cz, cy_dec};
      default: rd_addr = {cz, cy};
    endcase
  end

  // Read-modify-write of the centre row; ignored outside the active size.
  always_comb begin
    wr_row     = row;
    wr_row[cx] = sol;
  end
  assign wr_en = uc.wr && center_in;

  // Item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= opcode;
      cx  <= coord_x;
      cy  <= coord_y;
      cz  <= coord_z;
      sol <= solid;
    end
  end

  // Corner products: the low and high corner of each axis, times the voxel size.
  always_ff @(posedge clk) begin
    lo_x <= POS_W'(cx) * POS_W'(voxel_size);
    lo_y <= POS_W'(cy) * POS_W'(voxel_size);
    lo_z <= POS_W'(cz) * POS_W'(voxel_size);
    hi_x <= lo_x + POS_W'(voxel_size);
    hi_y <= lo_y + POS_W'(voxel_size);
    hi_z <= lo_z + POS_W'(voxel_size);
  end

  // Visible faces still to emit, and the lowest of them.
  assign mask     = csolid ? pend : '0;
  assign one_left = (mask != '0) && ((mask & (mask - NFACES'(1))) == '0);

  always_comb begin
    cur = FACE_ZP;
    for (int i = NFACES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        cur = FACE_W'(i);
      end
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign fire      = uc.emit && (mask != '0) && slot_free;
  assign last_v    = one_left && (vcnt == VTX_LAST);
  assign corner    = vfm_corner(cur, vcnt);

  // Neighbour capture and face bookkeeping; a set bit means the face shows.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
    end else begin
      case (uc.cap)
        CAP_C: begin
          row     <= rd_data;
          csolid  <= center_in && rd_data[cx];
          pend[2] <= !(xp_ok && rd_data[cx_inc]);
          pend[3] <= !((cx != '0) && rd_data[cx_dec]);
          vcnt    <= '0;
        end
        CAP_ZP: pend[0] <= !(zp_ok && rd_data[cx]);
        CAP_ZM: pend[1] <= !((cz != '0) && rd_data[cx]);
        CAP_YP: pend[4] <= !(yp_ok && rd_data[cx]);
        CAP_YM: pend[5] <= !((cy != '0) && rd_data[cx]);
        default: begin
          if (fire) begin
            if (vcnt == VTX_LAST) begin
              vcnt      <= '0;
              pend[cur] <= 1'b0;
            end else begin
              vcnt <= vcnt + VTX_W'(1);
            end
          end
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_x    <= corner[2] ? hi_x : lo_x;
      pos_y    <= corner[1] ? hi_y : lo_y;
      pos_z    <= corner[0] ? hi_z : lo_z;
      face_dir <= cur;
      last     <= last_v;
    end
  end

`ifndef NO_ASSERTIONS
  // The vertex counter never passes the sixth vertex of a face.
  a_vcnt_range: assert property (@(posedge clk) disable iff (rst)
    vcnt <= VTX_LAST)
    else $error("vertex counter out of range");

  // The beat carrying last ends the item and returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && last_v) |=> (step == ST_IDLE))
    else $error("sequencer not idle after last vertex");

  // The sequencer holds in idle throughout the clearing pass.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (step == ST_IDLE) && !in_ready)
    else $error("item handled during clearing pass");
`endif

endmodule

// ----- rtl/vfm_grid.sv -----
// Voxel bitmap store: one row of x voxels per (z, y), with a clearing pass after reset.
`timescale 1ns / 1ps
module vfm_grid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [vfm_pkg::ROW_AW-1:0]    rd_addr,
  output logic [vfm_pkg::MAX_SIZE-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [vfm_pkg::ROW_AW-1:0]    wr_addr,
  input  logic [vfm_pkg::MAX_SIZE-1:0]  wr_data,
  output logic                          busy
);
  import vfm_pkg::*;

  logic [MAX_SIZE-1:0] mem [MAX_SIZE*MAX_SIZE];
  logic [ROW_AW-1:0]   clr_cnt;

  // Clearing pass after reset: zeroes every row in turn, from address 0 to the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + ROW_AW'(1);
      if (&clr_cnt) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared with the clearing pass.
  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/vfm_seq.sv -----
// Microcode sequencer: step counter, program store and branch logic.
`timescale 1ns / 1ps
module vfm_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  vfm_pkg::seq_flags_t         flags,
  output logic [vfm_pkg::STEP_W-1:0]  step,
  output vfm_pkg::ucode_t             uc
);
  import vfm_pkg::*;

  logic [STEP_W-1:0] step_next;

  assign uc = ucode_rom(step);

  // Next step from the branch condition of the current word.
  always_comb begin
    unique case (uc.cond)
      CD_NEXT:     step_next = step + STEP_W'(1);
      CD_ACCEPT:   step_next = flags.accept ? step + STEP_W'(1) : step;
      CD_IF_WRITE: step_next = flags.is_write ? uc.target : step + STEP_W'(1);
      CD_EMIT:     step_next = flags.emit_done ? uc.target : step;
      CD_GOTO:     step_next = uc.target;
      default:     step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
